@@ design/asbs_pkg.sv @@
package asbs_pkg;

   localparam int unsigned SampleWidth  = 24;
   localparam int unsigned QuadletWidth = 32;

   localparam logic [7:0] LABEL_BYTE = 8'h40;
   localparam logic [3:0] SPECIAL_HI = 4'h9;
   localparam logic [3:0] POS_MAX    = 4'hf;
   localparam logic [4:0] RING_LEN   = 5'd15;

   typedef logic [3:0] nibble_type;
   typedef logic [7:0] byte_type;

   localparam nibble_type LEN_TAB [16] = '{
      4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13,
      4'd14, 4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0
   };

   localparam nibble_type LO_TAB [15] = '{
      4'h8, 4'h7, 4'h9, 4'h6, 4'ha, 4'h5, 4'hb, 4'h4,
      4'hc, 4'h3, 4'hd, 4'h2, 4'he, 4'h1, 4'hf
   };

   localparam nibble_type HI_RING [15] = '{
      4'h0, 4'h6, 4'hf, 4'h8, 4'h7, 4'h5, 4'h3, 4'h4,
      4'hc, 4'hd, 4'he, 4'h1, 4'h2, 4'hb, 4'ha
   };

   localparam nibble_type HI_START [16] = '{
      4'd0, 4'd11, 4'd12, 4'd6, 4'd7, 4'd5, 4'd1, 4'd4,
      4'd3, 4'd0, 4'd14, 4'd13, 4'd8, 4'd9, 4'd10, 4'd2
   };

   // Salt for the next channel from the key and the position (1 to 15).
   function automatic byte_type salt_of(input byte_type key, input nibble_type pos);
      nibble_type len;
      logic [4:0] lo_idx;
      logic [4:0] hi_idx;
      nibble_type lnib;
      nibble_type hnib;
      len = LEN_TAB[key[3:0]];
      // With pos no greater than len the index stays within 1 to 14.
      lo_idx = 5'd14 + {1'b0, pos} - {1'b0, len};
      lnib = LO_TAB[lo_idx[3:0]];
      hi_idx = {1'b0, HI_START[key[7:4]]} + {1'b0, pos};
      if (hi_idx >= RING_LEN) begin
         hi_idx = hi_idx - RING_LEN;
      end
      if (key[7:4] == SPECIAL_HI) begin
         hnib = SPECIAL_HI;
      end else begin
         hnib = HI_RING[hi_idx[3:0]];
      end
      if (len < pos) begin
         salt_of = 8'h00;
      end else begin
         salt_of = {hnib, lnib};
      end
   endfunction

endpackage

@@ design/audio_sample_byte_scrambler.sv @@
// Scrambles the middle byte of 24-bit audio samples, one channel per transfer, and emits
// each as a 32-bit quadlet with label 0x40 in the top byte. A transfer with tuser set
// starts a frame and clears the salt, key and position first. Each sample is registered
// on input, passes the salt tables once and lands in the output register, so a new
// sample can be taken every cycle while the result side is not stalled. The salt state
// is updated as a sample moves into the output register, which is what ties one sample
// to the next.
module audio_sample_byte_scrambler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] sample
   input  logic        req_tuser,   // [0] first_of_frame
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] quadlet
);

   logic                                   in_valid_ff;
   logic                                   in_first_ff;
   logic [asbs_pkg::SampleWidth-1:0]       in_sample_ff;
   logic                                   out_valid_ff;
   logic                                   out_valid_in;
   logic [asbs_pkg::QuadletWidth-1:0]      out_quadlet_ff;
   logic [asbs_pkg::QuadletWidth-1:0]      out_quadlet_in;
   asbs_pkg::byte_type                     salt_ff;
   asbs_pkg::byte_type                     salt_in;
   asbs_pkg::byte_type                     key_ff;
   asbs_pkg::byte_type                     key_in;
   asbs_pkg::nibble_type                   pos_ff;
   asbs_pkg::nibble_type                   pos_in;

   asbs_pkg::byte_type                     carry_cur;
   asbs_pkg::byte_type                     key_cur;
   asbs_pkg::nibble_type                   pos_cur;
   asbs_pkg::nibble_type                   pos_base;
   asbs_pkg::byte_type                     raw;
   logic                                   advance;
   logic                                   take;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      carry_cur = in_first_ff ? 8'h00 : salt_ff;
      key_cur   = in_first_ff ? 8'h00 : key_ff;
      pos_cur   = in_first_ff ? 4'h0 : pos_ff;
      raw       = in_sample_ff[15:8];
      if (raw != 8'h00) begin
         key_in   = raw ^ carry_cur;
         pos_base = 4'h0;
      end else begin
         key_in   = key_cur;
         pos_base = pos_cur;
      end
      pos_in  = (pos_base == asbs_pkg::POS_MAX) ? asbs_pkg::POS_MAX : pos_base + 4'h1;
      salt_in = asbs_pkg::salt_of(key_in, pos_in);
      out_quadlet_in = {asbs_pkg::LABEL_BYTE, in_sample_ff[23:16], raw ^ carry_cur,
                        in_sample_ff[7:0]};
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         salt_ff      <= '0;
         key_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         // The state moves on only when a sample passes into the output register.
         if (advance && in_valid_ff) begin
            salt_ff <= salt_in;
            key_ff  <= key_in;
            pos_ff  <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_first_ff  <= req_tuser;
         in_sample_ff <= req_tdata;
      end
      if (advance && in_valid_ff) begin
         out_quadlet_ff <= out_quadlet_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_quadlet_ff;

endmodule

@@ design/asbs_checker.sv @@
module asbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Every result carries the label in its top byte.
   label_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:24] == asbs_pkg::LABEL_BYTE)
      else $error("result without label byte");

   // Input back-pressure only arises from a result that is waiting to be taken.
   ready_check: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no pending result");

   // Nothing is presented in the cycle after reset.
   reset_check: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result presented straight after reset");

   // A stalled result holds.
   hold_check: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind audio_sample_byte_scrambler asbs_checker u_asbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ sim/tb_audio_sample_byte_scrambler.sv @@
`timescale 1ns / 1ps

module tb_audio_sample_byte_scrambler;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 500;   // per idling phase, four phases

   // Salt tables, indexed by key low nibble, lookup index and key high nibble.
   localparam logic [3:0] SEG_LEN [16] = '{
      4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13,
      4'd14, 4'd12, 4'd10, 4'd8, 4'd6, 4'd4, 4'd2, 4'd0
   };
   localparam logic [3:0] LO_NIB [15] = '{
      4'h8, 4'h7, 4'h9, 4'h6, 4'ha, 4'h5, 4'hb, 4'h4,
      4'hc, 4'h3, 4'hd, 4'h2, 4'he, 4'h1, 4'hf
   };
   localparam logic [3:0] HI_NIB [15] = '{
      4'h0, 4'h6, 4'hf, 4'h8, 4'h7, 4'h5, 4'h3, 4'h4,
      4'hc, 4'hd, 4'he, 4'h1, 4'h2, 4'hb, 4'ha
   };
   localparam logic [3:0] HI_OFFSET [16] = '{
      4'd0, 4'd11, 4'd12, 4'd6, 4'd7, 4'd5, 4'd1, 4'd4,
      4'd3, 4'd0, 4'd14, 4'd13, 4'd8, 4'd9, 4'd10, 4'd2
   };

   typedef struct {
      logic        first;
      logic [23:0] smp;
      int          reps;
      bit          pinned;
      logic [31:0] quadlet;
   } stim_row_type;

   typedef struct {
      bit          pinned;
      logic [31:0] quadlet;
   } pinned_rec_type;

   // A pinned quadlet is known by inspection: the salt is clear after a frame start.
   stim_row_type directed_rows [14] = '{
      '{1'b1, 24'h000000, 1,  1'b1, 32'h4000_0000},
      '{1'b1, 24'hffffff, 1,  1'b1, 32'h40ff_ffff},
      '{1'b0, 24'h000000, 1,  1'b0, 32'h0},
      '{1'b1, 24'h009500, 1,  1'b1, 32'h4000_9500},
      '{1'b0, 24'h5a005a, 1,  1'b0, 32'h0},
      '{1'b1, 24'h123812, 1,  1'b1, 32'h4012_3812},
      '{1'b0, 24'h000000, 15, 1'b0, 32'h0},
      '{1'b0, 24'h00ff00, 1,  1'b0, 32'h0},
      '{1'b1, 24'h00f000, 1,  1'b1, 32'h4000_f000},
      '{1'b0, 24'hffffff, 1,  1'b0, 32'h0},
      '{1'b1, 24'h000100, 1,  1'b1, 32'h4000_0100},
      '{1'b0, 24'h000000, 1,  1'b0, 32'h0},
      '{1'b0, 24'haa55aa, 1,  1'b0, 32'h0},
      '{1'b0, 24'h000000, 1,  1'b0, 32'h0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [23:0] sample
   logic        req_tuser  = 1'b0; // [0] first_of_frame
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] quadlet

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int errors        = 0;
   int cycle_count   = 0;

   logic [7:0]  carry_salt = '0;
   logic [7:0]  scramble_key = '0;
   logic [3:0]  key_age = '0;

   logic [31:0] quadlets_due[$];
   pinned_rec_type pinned_q[$];

   audio_sample_byte_scrambler uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] next_salt(input logic [7:0] k, input logic [3:0] p);
      int len;
      logic [3:0] hn;
      logic [3:0] ln;
      len = int'(SEG_LEN[k[3:0]]);
      if (len < int'(p)) begin
         return 8'h00;
      end
      ln = LO_NIB[(14 + int'(p) - len) % 15];
      if (k[7:4] == asbs_pkg::SPECIAL_HI) begin
         hn = asbs_pkg::SPECIAL_HI;
      end else begin
         hn = HI_NIB[(int'(HI_OFFSET[k[7:4]]) + int'(p)) % 15];
      end
      return {hn, ln};
   endfunction

   // Advances the scrambler state by one channel and returns its quadlet.
   task automatic scramble_channel(input logic first, input logic [23:0] smp,
                                   output logic [31:0] quadlet);
      logic [7:0] raw;
      logic [7:0] enc;
      raw = smp[15:8];
      if (first) begin
         carry_salt   = '0;
         scramble_key = '0;
         key_age      = '0;
      end
      if (raw != 8'h00) begin
         key_age      = '0;
         scramble_key = raw ^ carry_salt;
      end
      enc = raw ^ carry_salt;
      if (key_age != asbs_pkg::POS_MAX) begin
         key_age = key_age + 4'd1;
      end
      carry_salt = next_salt(scramble_key, key_age);
      quadlet = {asbs_pkg::LABEL_BYTE, smp[23:16], enc, smp[7:0]};
   endtask

   task automatic report_mismatch(input string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic send_channel(input logic first, input logic [23:0] smp,
                               input bit pinned, input logic [31:0] quadlet);
      pinned_rec_type rec;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      rec.pinned  = pinned;
      rec.quadlet = quadlet;
      pinned_q.push_back(rec);
      req_tvalid <= 1'b1;
      req_tuser  <= first;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      while (quadlets_due.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Results are checked before the accepted sample is predicted, at the same edge.
   always @(posedge clock) begin
      logic [31:0] want;
      pinned_rec_type rec;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (quadlets_due.size() == 0) begin
               report_mismatch($sformatf("quadlet %h with nothing due", rsp_tdata));
            end else begin
               want = quadlets_due.pop_front();
               if (rsp_tdata !== want) begin
                  report_mismatch($sformatf("quadlet got %h want %h", rsp_tdata, want));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            scramble_channel(req_tuser, req_tdata, want);
            rec = pinned_q.pop_front();
            quadlets_due.push_back(rec.pinned ? rec.quadlet : want);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_audio_sample_byte_scrambler: done, errors");
         $finish;
      end
   end

   initial begin
      int phase_send [4];
      int phase_stall [4];
      int zero_run;
      logic first;
      logic [7:0] mid;
      phase_send  = '{0, 53, 0, 30};
      phase_stall = '{0, 0, 53, 30};
      zero_run = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         repeat (directed_rows[r].reps) begin
            send_channel(directed_rows[r].first, directed_rows[r].smp,
                         directed_rows[r].pinned, directed_rows[r].quadlet);
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         req_tvalid <= 1'b0;
         // The sender holds off here until every outstanding quadlet is back.
         drain_results();
         send_idle_pct = phase_send[ph];
         stall_pct     = phase_stall[ph];
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            first = ($urandom_range(11) == 0);
            // Long runs of silent middle bytes drive the position into saturation.
            if (zero_run == 0 && $urandom_range(9) == 0) begin
               zero_run = $urandom_range(20, 8);
            end
            if (zero_run > 0) begin
               zero_run--;
               mid = 8'h00;
            end else if ($urandom_range(9) < 4) begin
               mid = 8'h00;
            end else begin
               mid = 8'($urandom);
            end
            send_channel(first, {8'($urandom), mid, 8'($urandom)}, 1'b0, 32'h0);
         end
      end

      req_tvalid <= 1'b0;
      drain_results();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("tb_audio_sample_byte_scrambler: done, clean");
      end else begin
         $display("tb_audio_sample_byte_scrambler: done, errors");
      end
      $finish;
   end

endmodule
